@@ src/sfx_pkg.sv @@
// ----------------------------------------------------------------------------
// sfx_pkg
// shared types and constants of the stuffed frame transmitter
// ----------------------------------------------------------------------------
package sfx_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7e;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7d;
    // second byte of an escape pair is the original byte with bit 5 flipped
    localparam logic [7:0] ESCAPE_XOR  = 8'h20;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL0 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL1 = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_sfx_in;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       burst_last;
    } t_sfx_out;

    // one classified payload byte handed from front to back
    typedef struct packed {
        logic       hdr;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] data;
        logic       has_check;
        logic [7:0] check;
    } t_sfx_cmd;

endpackage

@@ src/sfx_front.sv @@
// ----------------------------------------------------------------------------
// sfx_front
// takes payload words, tracks frame and sequence state, queues commands
// ----------------------------------------------------------------------------
module sfx_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sfx_pkg::t_sfx_in                 i_in_word,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sfx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output sfx_pkg::t_sfx_cmd                o_q_cmd
);
    import sfx_pkg::*;

    logic [7:0] r_address;
    logic [7:0] r_control0;
    logic [7:0] r_control1;
    logic       r_seq;
    logic       r_in_frame;
    logic [7:0] r_check;

    logic       accept;
    logic       n_seq;
    logic [7:0] n_check;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;

    always_comb begin
        n_seq   = r_in_frame ? r_seq : ~r_seq;
        n_check = (r_in_frame ? r_check : 8'h00) ^ i_in_word.data_byte;
        o_q_push          = accept;
        o_q_cmd.hdr       = !r_in_frame;
        o_q_cmd.addr      = r_address;
        o_q_cmd.ctrl      = n_seq ? r_control1 : r_control0;
        o_q_cmd.data      = i_in_word.data_byte;
        o_q_cmd.has_check = i_in_word.frame_end;
        o_q_cmd.check     = n_check;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address  <= 8'h03;
            r_control0 <= 8'h00;
            r_control1 <= 8'h40;
            r_seq      <= 1'b0;
            r_in_frame <= 1'b0;
            r_check    <= 8'h00;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ADDRESS:  r_address  <= i_cfg_data;
                    CFG_CONTROL0: r_control0 <= i_cfg_data;
                    CFG_CONTROL1: r_control1 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_seq      <= n_seq;
                r_in_frame <= !i_in_word.frame_end;
                r_check    <= i_in_word.frame_end ? 8'h00 : n_check;
            end
        end
    end

endmodule

@@ src/sfx_queue.sv @@
// ----------------------------------------------------------------------------
// sfx_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module sfx_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfx_pkg::t_sfx_cmd i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sfx_pkg::t_sfx_cmd o_cmd
);
    import sfx_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_sfx_cmd         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/sfx_back.sv @@
// ----------------------------------------------------------------------------
// sfx_back
// walks one command through header (if any), stuffed data, and check and closing flag (if any)
// ----------------------------------------------------------------------------
module sfx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  sfx_pkg::t_sfx_cmd i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sfx_pkg::t_sfx_out o_out_word
);
    import sfx_pkg::*;

    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_CTRL  = 3'd2;
    localparam logic [2:0] PH_BCC   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;
    localparam logic [2:0] PH_CLOSE = 3'd6;

    t_sfx_cmd   r_cmd;
    logic       r_busy;
    logic [2:0] r_phase;
    logic       r_esc;
    logic       r_out_valid;
    t_sfx_out   r_out;

    logic [2:0] n_phase;
    logic       n_esc;
    logic [7:0] cur_byte;
    logic [7:0] stuff_val;
    logic       fin;
    logic       advance;
    logic       slot_free;
    logic       emit;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign emit        = r_busy && slot_free;
    assign o_q_pop     = i_q_valid && (!r_busy || (emit && fin));
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_phase   = r_phase;
        n_esc     = r_esc;
        cur_byte  = FLAG_BYTE;
        fin       = 1'b0;
        advance   = 1'b0;
        stuff_val = (r_phase == PH_DATA) ? r_cmd.data : r_cmd.check;
        unique case (r_phase) inside
            PH_FLAG: begin
                cur_byte = FLAG_BYTE;
                n_phase  = PH_ADDR;
            end
            PH_ADDR: begin
                cur_byte = r_cmd.addr;
                n_phase  = PH_CTRL;
            end
            PH_CTRL: begin
                cur_byte = r_cmd.ctrl;
                n_phase  = PH_BCC;
            end
            PH_BCC: begin
                cur_byte = r_cmd.addr ^ r_cmd.ctrl;
                n_phase  = PH_DATA;
            end
            PH_DATA, PH_CHECK: begin
                if (r_esc) begin
                    cur_byte = stuff_val ^ ESCAPE_XOR;
                    n_esc    = 1'b0;
                    advance  = 1'b1;
                end else if (stuff_val == FLAG_BYTE || stuff_val == ESCAPE_BYTE) begin
                    cur_byte = ESCAPE_BYTE;
                    n_esc    = 1'b1;
                end else begin
                    cur_byte = stuff_val;
                    advance  = 1'b1;
                end
                if (advance) begin
                    if (r_phase == PH_CHECK) begin
                        n_phase = PH_CLOSE;
                    end else if (r_cmd.has_check) begin
                        n_phase = PH_CHECK;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            PH_CLOSE: begin
                cur_byte = FLAG_BYTE;
                fin      = 1'b1;
            end
            default: begin
                cur_byte = FLAG_BYTE;
                fin      = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (emit) begin
            r_out.line_byte  <= cur_byte;
            r_out.burst_last <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_FLAG;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy  <= 1'b1;
                r_phase <= i_q_cmd.hdr ? PH_FLAG : PH_DATA;
                r_esc   <= 1'b0;
            end else if (emit && fin) begin
                r_busy <= 1'b0;
                r_esc  <= 1'b0;
            end else if (emit) begin
                r_phase <= n_phase;
                r_esc   <= n_esc;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/stuffed_frame_transmitter_core.sv @@
// ----------------------------------------------------------------------------
// stuffed_frame_transmitter_core
// byte-stuffed information frame transmitter with xor check byte
// ----------------------------------------------------------------------------
// payload words enter on i_in_valid / o_in_stall, one byte per word with a
// frame_end mark on the final byte. line words leave on o_out_valid /
// i_out_stall, one byte per word, burst_last set on the last byte caused
// by one payload word. the first byte of a frame flips the sequence bit and
// brings a four-byte header (flag, address, control, xor of both); the last
// brings the stuffed check byte and a closing flag.
// registers are written on i_cfg_valid (o_cfg_ready is always high); the
// user writes them only while the block is idle, which the block does
// not enforce; indexes beyond the register list are ignored. the back
// end sends one line byte per cycle unless the receiver stalls; a word
// makes 1 to 9 line bytes: 1 for a plain byte, 2 when escaped, up to 9
// for a single-byte frame. a queue of QUEUE_DEPTH commands lets the input
// keep flowing while the back end expands a burst; when the receiver
// stalls the output word holds and the queue fills, then o_in_stall rises.
// reset clears the frame and sequence state, the queue and the output.
// ----------------------------------------------------------------------------
module stuffed_frame_transmitter_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sfx_pkg::t_sfx_in              i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sfx_pkg::t_sfx_out             o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import sfx_pkg::*;

    logic     q_full;
    logic     q_push;
    t_sfx_cmd q_in_cmd;
    logic     q_pop;
    logic     q_valid;
    t_sfx_cmd q_out_cmd;

    sfx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    sfx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    sfx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
